// ===== rtl/swma_pkg.sv =====
// ----------------------------------------------------------------------------
// swma_pkg
// Shared widths, defaults, state encoding and control bundles for the
// sliding-window moving average core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swma_pkg;

   localparam int SAMPLE_W           = 32;
   localparam int AVG_W              = 48;
   localparam int CNT_W              = 7;
   localparam int FRAC_W             = 16;
   localparam int WINDOW_MAX_DEFAULT = 64;

   localparam logic [CNT_W-1:0] WINDOW_RESET = 7'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_START,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic cfg_write;
      logic load;
      logic update;
      logic div_start;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/swma_ctrl.sv =====
// ----------------------------------------------------------------------------
// swma_ctrl
// Sequencer: takes a csr write or accepts a beat, steps the datapath through update and the
// serial divide, then parks the result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swma_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   output swma_pkg::cmd_type    cmd,
   input  swma_pkg::status_type status
);
   import swma_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      csr_ready = 1'b0;
      // config wins over a sample in the same cycle
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            csr_ready = 1'b1;
            req_stall = csr_valid;
            if (csr_valid) begin
               cmd.cfg_write = 1'b1;
            end else if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_START;
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/swma_datapath.sv =====
// ----------------------------------------------------------------------------
// swma_datapath
// Sample ring, running sum, fill/oldest tracking, restoring divider and
// the output payload register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swma_datapath #(
   parameter int WINDOW_MAX = swma_pkg::WINDOW_MAX_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  swma_pkg::cmd_type                   cmd,
   output swma_pkg::status_type                status,
   input  wire signed [swma_pkg::SAMPLE_W-1:0] req_sample,
   input  wire        [swma_pkg::CNT_W-1:0]    csr_window_size,
   output logic signed [swma_pkg::AVG_W-1:0]   rsp_average_q16,
   output logic       [swma_pkg::CNT_W-1:0]    rsp_samples_held
);
   import swma_pkg::*;

   localparam int CNT_MAX = (1 << CNT_W) - 1;
   localparam int EFF_MAX = (WINDOW_MAX < CNT_MAX) ? WINDOW_MAX : CNT_MAX;
   localparam int ADDR_W  = $clog2(WINDOW_MAX);
   localparam int IDX_W   = (ADDR_W > CNT_W) ? ADDR_W : CNT_W;
   localparam int SUM_W   = SAMPLE_W + $clog2(EFF_MAX);
   localparam int DVD_W   = SUM_W + FRAC_W;
   localparam int STEP_W  = $clog2(DVD_W);

   // configuration and window bookkeeping
   logic        [CNT_W-1:0]    window_ff;
   logic        [CNT_W-1:0]    fill_ff, fill_in;
   logic        [ADDR_W-1:0]   oldest_ff, oldest_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic        [CNT_W-1:0]    eff_win;
   logic                       full_now;
   logic        [IDX_W-1:0]    fill_ext;
   logic        [ADDR_W-1:0]   slot_now;
   logic        [IDX_W-1:0]    slot_next;

   // per-beat holding registers
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] old_ff;
   logic        [ADDR_W-1:0]   slot_ff;
   logic                       full_ff;
   logic signed [SUM_W-1:0]    old_term;

   logic        [SAMPLE_W-1:0] ring [WINDOW_MAX];

   // divider
   logic        [DVD_W-1:0]    dvd_ff, dvd_in;
   logic        [CNT_W-1:0]    rem_ff, rem_in;
   logic                       neg_ff;
   logic        [STEP_W-1:0]   step_ff;
   logic        [SUM_W-1:0]    sum_mag;
   logic        [CNT_W:0]      rem_sh, rem_diff;
   logic        [DVD_W-1:0]    quot_signed;

   always_comb begin
      if (window_ff == '0) begin
         eff_win = CNT_W'(1);
      end else if (window_ff > CNT_W'(EFF_MAX)) begin
         eff_win = CNT_W'(EFF_MAX);
      end else begin
         eff_win = window_ff;
      end
   end

   assign full_now  = (fill_ff >= eff_win);
   assign fill_ext  = IDX_W'(fill_ff);
   assign slot_now  = full_now ? oldest_ff : fill_ext[ADDR_W-1:0];
   assign slot_next = IDX_W'(slot_ff) + IDX_W'(1);
   assign old_term  = full_ff ? SUM_W'(old_ff) : '0;

   always_comb begin
      sum_in    = sum_ff + SUM_W'(sample_ff) - old_term;
      fill_in   = fill_ff;
      oldest_in = oldest_ff;
      if (full_ff) begin
         fill_in = eff_win;
         if (slot_next == IDX_W'(eff_win)) begin
            oldest_in = '0;
         end else begin
            oldest_in = slot_next[ADDR_W-1:0];
         end
      end else begin
         fill_in = fill_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         fill_ff   <= '0;
         oldest_ff <= '0;
         sum_ff    <= '0;
      end else if (cmd.cfg_write) begin
         window_ff <= csr_window_size;
         fill_ff   <= '0;
         oldest_ff <= '0;
         sum_ff    <= '0;
      end else if (cmd.update) begin
         fill_ff   <= fill_in;
         oldest_ff <= oldest_in;
         sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_sample;
         slot_ff   <= slot_now;
         full_ff   <= full_now;
      end
   end

   // ring: read the leaving sample on accept, write the new one on update
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         old_ff <= ring[slot_now];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         ring[slot_ff] <= sample_ff;
      end
   end

   // restoring divide of |sum| << 16 by the fill count, one bit a cycle
   assign sum_mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign rem_sh   = {rem_ff, dvd_ff[DVD_W-1]};
   assign rem_diff = rem_sh - {1'b0, fill_ff};

   always_comb begin
      if (rem_diff[CNT_W]) begin
         rem_in = rem_sh[CNT_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
      end else begin
         rem_in = rem_diff[CNT_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff  <= {sum_mag, FRAC_W'(0)};
         rem_ff  <= '0;
         neg_ff  <= sum_ff[SUM_W-1];
         step_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff  <= dvd_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   assign status.div_last = (step_ff == STEP_W'(DVD_W - 1));
   assign quot_signed     = neg_ff ? (~dvd_ff + DVD_W'(1)) : dvd_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_average_q16  <= quot_signed[AVG_W-1:0];
         rsp_samples_held <= fill_ff;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sliding_window_moving_average_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_moving_average_core
// Simple moving average over the last window_size samples, Q.16 output.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_sample
//   rsp      out  rsp_valid/rsp_stall   rsp_average_q16, rsp_samples_held
//   csr      in   csr_valid/csr_ready   csr_window_size
//
// A beat passes through accept, sum update, divider load, the restoring
// divider at one quotient bit a cycle, then the hand-off into the output
// register.
// The output register lets the next beat enter while a result waits.
// Reset: window_size = 4, window empty; the ring needs no clearing.
// A csr write empties the window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_moving_average_core #(
   parameter int WINDOW_MAX = swma_pkg::WINDOW_MAX_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire signed [swma_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic signed [swma_pkg::AVG_W-1:0]   rsp_average_q16,
   output logic       [swma_pkg::CNT_W-1:0]    rsp_samples_held,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire        [swma_pkg::CNT_W-1:0]    csr_window_size
);
   import swma_pkg::*;

   cmd_type    cmd;
   status_type status;

   swma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .status    (status)
   );

   swma_datapath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample       (req_sample),
      .csr_window_size  (csr_window_size),
      .rsp_average_q16  (rsp_average_q16),
      .rsp_samples_held (rsp_samples_held)
   );

endmodule

`default_nettype wire

// ===== rtl/swma_checker.sv =====
// ----------------------------------------------------------------------------
// swma_checker
// Port-level checks for the moving average core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swma_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_valid,
   input wire                                 req_stall,
   input wire                                 rsp_valid,
   input wire                                 rsp_stall,
   input wire signed [swma_pkg::AVG_W-1:0]    rsp_average_q16,
   input wire        [swma_pkg::CNT_W-1:0]    rsp_samples_held,
   input wire                                 csr_valid,
   input wire                                 csr_ready
);
   import swma_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_average_q16)
         && $stable(rsp_samples_held))
      else $error("rsp beat changed while stalled");

   // one beat in flight: the core is busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req accepted while previous beat in flight");

   // a csr write and a sample never land on the same edge
   a_csr_excl: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> req_stall)
      else $error("csr write and req beat accepted together");

   // every result holds at least the sample that made it
   a_held_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_samples_held != '0)
      else $error("result with empty window");

   // csr port only open while no sample is being worked on
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !$past(req_valid && !req_stall))
      else $error("csr ready right after a req accept");

endmodule

bind sliding_window_moving_average_core swma_checker u_swma_checker (.*);

`default_nettype wire
